// ===== hw/rtl/rlu_pkg.sv =====
// rlu_pkg: shared constants for the run-length literal unpacker
// no dependencies; imported by run_length_literal_unpacker_top

package rlu_pkg;

  localparam int BYTES_PER_RESULT = 4;
  localparam int LANES            = 4;
  localparam int MAX_RESULTS      = 64;

  // packing width clamped between 1 and the available output lanes
  localparam int PACK_W = (BYTES_PER_RESULT < 1) ? 1 :
                          (BYTES_PER_RESULT > LANES) ? LANES : BYTES_PER_RESULT;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 3;
  localparam int RES_CNT_W  = $clog2(MAX_RESULTS);
  localparam int OUT_DATA_W = 40;

  localparam logic [BYTE_W-1:0] DEFAULT_MARKER = 8'hFF;

endpackage

// ===== hw/rtl/run_length_literal_unpacker_top.sv =====
// A literal data byte gives its word in the cycle after it is taken.
// After a repeat value byte, the shared subtract/pack unit sends one word
// per cycle while the output slot is free: ceil(N/4) words for a count N,
// in_tready low meanwhile. Header and count bytes give no word.
// Reset (rst_n, synchronous, active low): marker back to 0xFF, expect a header,
// output word empty.

module run_length_literal_unpacker_top
  import rlu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [BYTE_W-1:0]     cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,     // [7:0] packed_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // [7:0] out_byte0, [15:8] out_byte1,
                                              // [23:16] out_byte2, [31:24] out_byte3,
                                              // [34:32] byte_count, [39:35] zero
  output logic                  out_tlast     // last_of_run
);

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_LIT_COUNT,
    ST_LIT_DATA,
    ST_REP_VALUE,
    ST_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [BYTE_W-1:0]         marker_r, marker_nxt;
  logic [BYTE_W-1:0]         remain_r, remain_nxt;
  logic [BYTE_W-1:0]         value_r, value_nxt;
  logic [RES_CNT_W-1:0]      res_cnt_r, res_cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [LANES*BYTE_W-1:0]   out_bytes_r, out_bytes_nxt;
  logic [CNT_W-1:0]          out_cnt_r, out_cnt_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      slot_free;
  logic                      in_acc;
  logic [CNT_W-1:0]          take_n;
  logic [BYTE_W-1:0]         left_after;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r != ST_EMIT) && slot_free;
  assign in_acc    = in_tvalid && in_tready;

  // shared unit: bytes for this word and what is left after it
  assign take_n     = (remain_r < BYTE_W'(PACK_W)) ? remain_r[CNT_W-1:0] : CNT_W'(PACK_W);
  assign left_after = remain_r - {{(BYTE_W-CNT_W){1'b0}}, take_n};

  always_comb begin
    state_nxt     = state_r;
    marker_nxt    = cfg_wr_en ? cfg_wr_data : marker_r;
    remain_nxt    = remain_r;
    value_nxt     = value_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    if (slot_free) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_HEADER: begin
        if (in_acc) begin
          if (in_tdata == marker_r) begin
            state_nxt = ST_LIT_COUNT;
          end else begin
            remain_nxt = in_tdata;
            state_nxt  = ST_REP_VALUE;
          end
        end
      end
      ST_LIT_COUNT: begin
        if (in_acc) begin
          remain_nxt = in_tdata;
          state_nxt  = (in_tdata == '0) ? ST_HEADER : ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = {{((LANES-1)*BYTE_W){1'b0}}, in_tdata};
          out_cnt_nxt   = CNT_W'(1);
          out_last_nxt  = 1'b1;
          remain_nxt    = remain_r - BYTE_W'(1);
          if (remain_r == BYTE_W'(1)) begin
            state_nxt = ST_HEADER;
          end
        end
      end
      ST_REP_VALUE: begin
        if (in_acc) begin
          value_nxt   = in_tdata;
          res_cnt_nxt = '0;
          state_nxt   = (remain_r == '0) ? ST_HEADER : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          for (int j = 0; j < LANES; j++) begin
            out_bytes_nxt[j*BYTE_W +: BYTE_W] =
              (CNT_W'(j) < take_n) ? value_r : '0;
          end
          out_cnt_nxt = take_n;
          remain_nxt  = left_after;
          res_cnt_nxt = res_cnt_r + RES_CNT_W'(1);
          // stop when the count is used up or the word limit is reached
          if (left_after == '0 || res_cnt_r == RES_CNT_W'(MAX_RESULTS-1)) begin
            out_last_nxt = 1'b1;
            remain_nxt   = '0;
            state_nxt    = ST_HEADER;
          end else begin
            out_last_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HEADER;
      marker_r    <= DEFAULT_MARKER;
      remain_r    <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marker_r    <= marker_nxt;
      remain_r    <= remain_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r     <= value_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-LANES*BYTE_W-CNT_W){1'b0}}, out_cnt_r, out_bytes_r};
  assign out_tlast  = out_last_r;

  // no input taken while a repeat run is being expanded
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_tready)
    else $error("input accepted during repeat expansion");

  // a literal data byte gives exactly one marked word next cycle
  a_literal_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && state_r == ST_LIT_DATA |=> out_valid_r && out_last_r && out_cnt_r == CNT_W'(1))
    else $error("literal byte did not produce a single-byte last word");

  // every presented word carries a byte count within the packing width
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != '0) && (out_cnt_r <= CNT_W'(PACK_W)))
    else $error("word byte count out of range");

endmodule
